// ===== hdl/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// epm_pkg
// shared types and constants of the exact pattern match unit
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int SYM_W   = 8;
  localparam int START_W = 16;

  // depth of the queue between front and back end, a power of two
  localparam int QUEUE_DEPTH = 2;

  // action codes carried in tuser
  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  // one classified word handed from the front end to the back end
  typedef struct packed {
    logic               is_text;
    logic               in_range;  // text word below the text length limit
    logic               last;
    logic [SYM_W-1:0]   sym;
    logic [START_W-1:0] pos;       // text index, low bits
  } epm_cmd_t;

endpackage

// ===== hdl/epm_front.sv =====
// ----------------------------------------------------------------------------
// epm_front
// accepts input words, tracks the text index and classifies each word
// ----------------------------------------------------------------------------
module epm_front import epm_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SYM_W-1:0] s_tdata,
  input  logic             s_tuser,
  input  logic             s_tlast,
  input  logic             q_full,
  output logic             q_push,
  output epm_cmd_t         q_cmd
);

  localparam int PW = $clog2(MAX_TEXT + 1);

  logic [PW-1:0] pos;
  logic          in_range;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign in_range = pos < PW'(MAX_TEXT);

  always_comb begin
    q_cmd.is_text  = (s_tuser == ACT_TEXT);
    q_cmd.in_range = in_range;
    q_cmd.last     = s_tlast;
    q_cmd.sym      = s_tdata;
    q_cmd.pos      = START_W'(pos);
  end

  // position saturates at the limit until the text ends
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      if (s_tuser == ACT_PATTERN || s_tlast) begin
        pos <= '0;
      end else if (in_range) begin
        pos <= PW'(pos + 1'b1);
      end
    end
  end

endmodule

// ===== hdl/epm_queue.sv =====
// ----------------------------------------------------------------------------
// epm_queue
// short first-in first-out queue of classified words
// ----------------------------------------------------------------------------
module epm_queue import epm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  epm_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output epm_cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  epm_cmd_t         slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== hdl/epm_back.sv =====
// ----------------------------------------------------------------------------
// epm_back
// pattern store, text window, window compare and output register
// ----------------------------------------------------------------------------
module epm_back import epm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  epm_cmd_t           head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [START_W-1:0] m_tdata
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // index 0 holds the newest byte in both shift lines
  logic [SYM_W-1:0] pat     [MAX_PATTERN];
  logic [SYM_W-1:0] win     [MAX_PATTERN];
  logic [SYM_W-1:0] win_new [MAX_PATTERN];

  logic [LW-1:0]          len;
  logic                   complete;
  logic                   overlong;
  logic [LW-1:0]          fill;
  logic [LW-1:0]          fill_inc;
  logic [LW-1:0]          len_base;
  logic                   can_store;
  logic [MAX_PATTERN-1:0] hit;
  logic                   match;
  logic                   shift_text;

  assign pop        = q_valid && (!m_tvalid || m_tready);
  assign shift_text = pop && head.is_text && head.in_range;
  assign len_base   = complete ? '0 : len;
  assign can_store  = len_base < LW'(MAX_PATTERN);
  assign fill_inc   = (fill < LW'(MAX_PATTERN)) ? LW'(fill + 1'b1) : fill;

  always_comb begin
    win_new[0] = head.sym;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_new[k] = win[k-1];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      hit[k] = (LW'(k) >= len) || (win_new[k] == pat[k]);
    end
    match = complete && !overlong && (len != '0) && (fill_inc >= len) && (&hit);
  end

  // storage lines, no reset needed
  always_ff @(posedge clk) begin
    if (pop && !head.is_text && can_store) begin
      pat[0] <= head.sym;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        pat[k] <= pat[k-1];
      end
    end
    if (shift_text) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      complete <= 1'b0;
      overlong <= 1'b0;
      fill     <= '0;
    end else if (pop) begin
      if (!head.is_text) begin
        len      <= can_store ? LW'(len_base + 1'b1) : len_base;
        overlong <= (overlong && !complete) || !can_store;
        complete <= head.last;
        fill     <= '0;
      end else if (head.last) begin
        fill <= '0;
      end else if (head.in_range) begin
        fill <= fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (shift_text && match) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_text && match) begin
      m_tdata <= START_W'(head.pos + START_W'(1) - START_W'(len));
    end
  end

endmodule

// ===== hdl/exact_pattern_match_unit.sv =====
// ----------------------------------------------------------------------------
// exact_pattern_match_unit
// streaming exact pattern matcher reporting every occurrence start index
// ----------------------------------------------------------------------------
// Load a pattern as words with tuser low, the final byte marked by tlast, then
// stream text words with tuser high; every index at which the whole pattern
// ends up in the text window is sent out as one word, overlapping hits
// included, in ascending order. Loading any pattern byte clears the window and
// restarts the text index; a text word with tlast restarts it too. Pattern
// bytes beyond MAX_PATTERN mark the pattern overlong and nothing is reported
// for it. Text words at index MAX_TEXT or above give nothing until tlast. The
// unit takes one word per clock while the queue is not full: a front end
// classifies words and tracks the text index, a two-word queue decouples it
// from the back end, and the back end compares the whole window against the
// pattern combinationally, which sets the clock limit. A hit for an accepted
// text word passes a queue slot and then the m_tvalid register; input only
// stalls once the output word is held and the queue has filled behind it.
// ----------------------------------------------------------------------------
module exact_pattern_match_unit import epm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SYM_W-1:0]   s_tdata,   // [7:0] symbol
  input  logic               s_tuser,   // [0] action: pattern or text
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [START_W-1:0] m_tdata    // [15:0] match_start
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  epm_cmd_t q_cmd;
  epm_cmd_t q_head;

  // front end: handshake, text index, word classification
  epm_front #(
    .MAX_TEXT (MAX_TEXT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // decoupling queue
  epm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back end: pattern store, window compare, output register
  epm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/epm_checker.sv =====
// ----------------------------------------------------------------------------
// epm_checker
// port-level checks of the exact pattern match unit
// ----------------------------------------------------------------------------
module epm_checker import epm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [START_W-1:0] m_tdata
);

  // a held output word stays put
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // reset empties the queue, so input is open right after
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // input only closes behind a stalled output word
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

endmodule

bind exact_pattern_match_unit epm_checker u_epm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
